// ===== rtl/cda_pkg.sv =====
`default_nettype none

package cda_pkg;

    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int YEAR_W     = 12;
    localparam int COUNT_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int YMOD_W     = 7;
    localparam int CMOD_W     = 2;

    localparam int COUNT_BITS_DEF = 16;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 12'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 12'd2100;
    localparam logic [YEAR_W-1:0]  YEAR_LIMIT = 12'd4095;
    localparam logic [YEAR_W-1:0]  CENTURY    = 12'd100;
    localparam logic [YMOD_W-1:0]  YMOD_LAST  = 7'd99;
    // Century count of the lowest loadable year, modulo four.
    localparam logic [CMOD_W-1:0]  CMOD_BASE  = 2'd3;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LEAP   = 5'd29;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_MONTH = 3'd1,
        ST_BAD_YEAR  = 3'd2,
        ST_BAD_DAY   = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef struct packed {
        logic capture;
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic at_limit;
    } t_stat;

    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    // A year is leap when it is a multiple of four and either not a century
    // year or a century year whose century count is a multiple of four.
    function automatic logic is_leap(input logic [1:0] year_low,
                                     input logic [YMOD_W-1:0] ymod,
                                     input logic [CMOD_W-1:0] cmod);
        is_leap = (year_low == 2'd0) && ((ymod != '0) || (cmod == '0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        if (month == MONTH_FEB && leap) begin
            days_in = DAY_LEAP;
        end else begin
            days_in = MONTH_LEN[month];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cda_ctrl.sv =====
`default_nettype none

module cda_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_kind,
    input  wire cda_pkg::t_stat i_stat,
    output logic               busy,
    output cda_pkg::t_cmd      o_cmd
);
    import cda_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_ADV  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_kind == KIND_ADVANCE) ? S_ADV : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = S_IDLE;
            end
            S_ADV: begin
                if (i_stat.count_zero || i_stat.at_limit) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/cda_datapath.sv =====
`default_nettype none

module cda_datapath #(
    parameter int COUNT_BITS = cda_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire cda_pkg::t_cmd                   i_cmd,
    output cda_pkg::t_stat                       o_stat,
    input  wire logic [cda_pkg::MONTH_W-1:0]     i_month_in,
    input  wire logic [cda_pkg::DAY_W-1:0]       i_day_in,
    input  wire logic [cda_pkg::YEAR_W-1:0]      i_year_in,
    input  wire logic [cda_pkg::COUNT_W-1:0]     i_day_count,
    output logic                                 o_valid,
    output logic [cda_pkg::MONTH_W-1:0]          o_out_month,
    output logic [cda_pkg::DAY_W-1:0]            o_out_day,
    output logic [cda_pkg::YEAR_W-1:0]           o_out_year,
    output logic [cda_pkg::STATUS_W-1:0]         o_status
);
    import cda_pkg::*;

    localparam int CntW = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;

    logic [MONTH_W-1:0]  r_month, n_month;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [YEAR_W-1:0]   r_year, n_year;
    logic [YMOD_W-1:0]   r_ymod, n_ymod;
    logic [CMOD_W-1:0]   r_cmod, n_cmod;
    logic                r_valid, n_valid;

    logic [MONTH_W-1:0]  r_lm, n_lm;
    logic [DAY_W-1:0]    r_ld, n_ld;
    logic [YEAR_W-1:0]   r_ly, n_ly;
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic [MONTH_W-1:0]  r_o_month, n_o_month;
    logic [DAY_W-1:0]    r_o_day, n_o_day;
    logic [YEAR_W-1:0]   r_o_year, n_o_year;
    t_status             r_o_status, n_o_status;

    logic [YEAR_W-1:0]   ld_off;
    logic [YMOD_W-1:0]   ld_ymod;
    logic [CMOD_W-1:0]   ld_cmod;
    logic                ld_leap;
    logic [DAY_W-1:0]    ld_dim;
    t_status             ld_status;
    logic                cur_leap;
    logic [DAY_W-1:0]    cur_dim;
    logic                month_end;

    // The loadable years span at most three centuries from the lowest one.
    always_comb begin
        ld_off = r_ly - YEAR_MIN;
        if (ld_off < CENTURY) begin
            ld_ymod = ld_off[YMOD_W-1:0];
            ld_cmod = CMOD_BASE;
        end else if (ld_off < (CENTURY << 1)) begin
            ld_ymod = YMOD_W'(ld_off - CENTURY);
            ld_cmod = CMOD_BASE + 2'd1;
        end else begin
            ld_ymod = YMOD_W'(ld_off - (CENTURY << 1));
            ld_cmod = CMOD_BASE + 2'd2;
        end
        ld_leap = is_leap(r_ly[1:0], ld_ymod, ld_cmod);
        ld_dim  = days_in(r_lm, ld_leap);
        priority if (r_lm == '0 || r_lm > MONTH_DEC) begin
            ld_status = ST_BAD_MONTH;
        end else if (r_ly < YEAR_MIN || r_ly > YEAR_MAX) begin
            ld_status = ST_BAD_YEAR;
        end else if (r_ld == '0 || r_ld > ld_dim) begin
            ld_status = ST_BAD_DAY;
        end else begin
            ld_status = ST_OK;
        end
    end

    assign cur_leap  = is_leap(r_year[1:0], r_ymod, r_cmod);
    assign cur_dim   = days_in(r_month, cur_leap);
    assign month_end = (r_day >= cur_dim);

    assign o_stat.count_zero = (r_cnt == '0);
    assign o_stat.at_limit   = month_end && (r_month >= MONTH_DEC) && (r_year == YEAR_LIMIT);

    always_comb begin
        n_month    = r_month;
        n_day      = r_day;
        n_year     = r_year;
        n_ymod     = r_ymod;
        n_cmod     = r_cmod;
        n_valid    = 1'b0;
        n_lm       = r_lm;
        n_ld       = r_ld;
        n_ly       = r_ly;
        n_cnt      = r_cnt;
        n_o_month  = r_o_month;
        n_o_day    = r_o_day;
        n_o_year   = r_o_year;
        n_o_status = r_o_status;

        if (i_cmd.capture) begin
            n_lm  = i_month_in;
            n_ld  = i_day_in;
            n_ly  = i_year_in;
            n_cnt = i_day_count[CntW-1:0];
        end

        if (i_cmd.load) begin
            n_valid    = 1'b1;
            n_o_status = ld_status;
            if (ld_status == ST_OK) begin
                n_month   = r_lm;
                n_day     = r_ld;
                n_year    = r_ly;
                n_ymod    = ld_ymod;
                n_cmod    = ld_cmod;
                n_o_month = r_lm;
                n_o_day   = r_ld;
                n_o_year  = r_ly;
            end else begin
                n_o_month = r_month;
                n_o_day   = r_day;
                n_o_year  = r_year;
            end
        end

        if (i_cmd.step) begin
            n_cnt = r_cnt - CntW'(1);
            priority if (!month_end) begin
                n_day = r_day + DAY_W'(1);
            end else if (r_month < MONTH_DEC) begin
                n_month = r_month + MONTH_W'(1);
                n_day   = DAY_FIRST;
            end else begin
                n_year  = r_year + YEAR_W'(1);
                n_month = MONTH_JAN;
                n_day   = DAY_FIRST;
                if (r_ymod == YMOD_LAST) begin
                    n_ymod = '0;
                    n_cmod = r_cmod + CMOD_W'(1);
                end else begin
                    n_ymod = r_ymod + YMOD_W'(1);
                end
            end
        end

        if (i_cmd.finish) begin
            n_valid    = 1'b1;
            n_o_month  = r_month;
            n_o_day    = r_day;
            n_o_year   = r_year;
            n_o_status = (r_cnt != '0) ? ST_OVERFLOW : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_month <= MONTH_JAN;
            r_day   <= DAY_FIRST;
            r_year  <= YEAR_MIN;
            r_ymod  <= '0;
            r_cmod  <= CMOD_BASE;
            r_valid <= 1'b0;
        end else begin
            r_month <= n_month;
            r_day   <= n_day;
            r_year  <= n_year;
            r_ymod  <= n_ymod;
            r_cmod  <= n_cmod;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lm       <= n_lm;
        r_ld       <= n_ld;
        r_ly       <= n_ly;
        r_cnt      <= n_cnt;
        r_o_month  <= n_o_month;
        r_o_day    <= n_o_day;
        r_o_year   <= n_o_year;
        r_o_status <= n_o_status;
    end

    assign o_valid     = r_valid;
    assign o_out_month = r_o_month;
    assign o_out_day   = r_o_day;
    assign o_out_year  = r_o_year;
    assign o_status    = r_o_status;

endmodule

`default_nettype wire

// ===== rtl/calendar_date_advance.sv =====
`default_nettype none

// Holds a Gregorian date and either loads a checked new date or advances the
// held date by a number of days. An item is taken when start is high while
// busy is low; its single result beat appears on the output ports for one
// cycle with o_valid high and must be taken then, since the receiver cannot
// stall the block. A load is captured, then checked in the load state, and
// its result beat is registered from there. An advance by N days moves the
// date one day per cycle through a single day-step unit; a count that would
// run past the last day of year 4095 ends there early with the overflow status.
// The next item can be accepted in the same cycle that a result beat is shown.

module calendar_date_advance #(
    parameter int COUNT_BITS = cda_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_kind,
    input  wire logic [cda_pkg::MONTH_W-1:0]     i_month_in,
    input  wire logic [cda_pkg::DAY_W-1:0]       i_day_in,
    input  wire logic [cda_pkg::YEAR_W-1:0]      i_year_in,
    input  wire logic [cda_pkg::COUNT_W-1:0]     i_day_count,
    output logic                                 o_valid,
    output logic [cda_pkg::MONTH_W-1:0]          o_out_month,
    output logic [cda_pkg::DAY_W-1:0]            o_out_day,
    output logic [cda_pkg::YEAR_W-1:0]           o_out_year,
    output logic [cda_pkg::STATUS_W-1:0]         o_status
);
    import cda_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    cda_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_month_in  (i_month_in),
        .i_day_in    (i_day_in),
        .i_year_in   (i_year_in),
        .i_day_count (i_day_count),
        .o_valid     (o_valid),
        .o_out_month (o_out_month),
        .o_out_day   (o_out_day),
        .o_out_year  (o_out_year),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

// ===== rtl/cda_checker.sv =====
`default_nettype none

module cda_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            start,
    input wire logic                            busy,
    input wire logic                            o_valid,
    input wire logic [cda_pkg::MONTH_W-1:0]     o_out_month,
    input wire logic [cda_pkg::DAY_W-1:0]       o_out_day,
    input wire logic [cda_pkg::YEAR_W-1:0]      o_out_year,
    input wire logic [cda_pkg::STATUS_W-1:0]    o_status
);
    import cda_pkg::*;

    // A result beat is only shown once the block is free again.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat repeated");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_month >= MONTH_JAN && o_out_month <= MONTH_DEC
                     && o_out_day != '0 && o_out_year >= YEAR_MIN
                     && o_status <= ST_OVERFLOW))
        else $error("result date or status out of range");

    a_overflow_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OVERFLOW) |->
            (o_out_month == MONTH_DEC && o_out_day == 5'd31 && o_out_year == YEAR_LIMIT))
        else $error("overflow result not at the last day");

endmodule

bind calendar_date_advance cda_checker u_cda_checker (.*);

`default_nettype wire

// ===== tb/tb_calendar_date_advance.sv =====
`default_nettype none

module tb_calendar_date_advance;

    import cda_pkg::*;

    localparam int RANDOM_ITEMS   = 1500;
    localparam int MAX_REPORTS    = 40;
    localparam int FULL_COUNT     = 65535;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SLACK_CYCLES   = 5000;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
        t_status            status;
    } t_date_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                i_kind      = KIND_LOAD;
    logic [MONTH_W-1:0]  i_month_in  = '0;
    logic [DAY_W-1:0]    i_day_in    = '0;
    logic [YEAR_W-1:0]   i_year_in   = '0;
    logic [COUNT_W-1:0]  i_day_count = '0;
    logic                busy;
    logic                o_valid;
    logic [MONTH_W-1:0]  o_out_month;
    logic [DAY_W-1:0]    o_out_day;
    logic [YEAR_W-1:0]   o_out_year;
    logic [STATUS_W-1:0] o_status;

    // Calendar state as the block should hold it.
    logic [MONTH_W-1:0]  cal_month = MONTH_JAN;
    logic [DAY_W-1:0]    cal_day   = DAY_FIRST;
    logic [YEAR_W-1:0]   cal_year  = YEAR_MIN;

    t_date_result expected_dates [$];
    t_date_result oldest_date;

    int     error_count    = 0;
    int     beats_checked  = 0;
    int     loads_sent     = 0;
    int     loads_rejected = 0;
    int     advances_sent  = 0;
    int     overflow_beats = 0;
    longint days_requested = 0;
    longint cycle_count    = 0;
    longint cycle_allowance = 0;
    bit     no_idle        = 1'b0;

    calendar_date_advance i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_month_in  (i_month_in),
        .i_day_in    (i_day_in),
        .i_year_in   (i_year_in),
        .i_day_count (i_day_count),
        .o_valid     (o_valid),
        .o_out_month (o_out_month),
        .o_out_day   (o_out_day),
        .o_out_year  (o_out_year),
        .o_status    (o_status)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic bit year_is_leap(input int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int month_length(input int m, input int y);
        case (m)
            2: begin
                month_length = year_is_leap(y) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                month_length = 30;
            end
            1, 3, 5, 7, 8, 10, 12: begin
                month_length = 31;
            end
            default: begin
                month_length = 0;
            end
        endcase
    endfunction

    task automatic predict_date(input logic kind, input logic [MONTH_W-1:0] m,
                                input logic [DAY_W-1:0] d, input logic [YEAR_W-1:0] y,
                                input logic [COUNT_W-1:0] cnt, output t_date_result res);
        int i;
        res.status = ST_OK;
        if (kind == KIND_LOAD) begin
            if (m < MONTH_JAN || m > MONTH_DEC) begin
                res.status = ST_BAD_MONTH;
            end else if (y < YEAR_MIN || y > YEAR_MAX) begin
                res.status = ST_BAD_YEAR;
            end else if (d < DAY_FIRST || d > month_length(m, y)) begin
                res.status = ST_BAD_DAY;
            end else begin
                cal_month = m;
                cal_day   = d;
                cal_year  = y;
            end
        end else begin
            for (i = 0; i < int'(cnt) && res.status == ST_OK; i++) begin
                if (cal_day < month_length(cal_month, cal_year)) begin
                    cal_day = cal_day + 1'b1;
                end else if (cal_month < MONTH_DEC) begin
                    cal_month = cal_month + 1'b1;
                    cal_day   = DAY_FIRST;
                end else if (cal_year >= YEAR_LIMIT) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    cal_year  = cal_year + 1'b1;
                    cal_month = MONTH_JAN;
                    cal_day   = DAY_FIRST;
                end
            end
        end
        res.month = cal_month;
        res.day   = cal_day;
        res.year  = cal_year;
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic kind, input logic [MONTH_W-1:0] m,
                             input logic [DAY_W-1:0] d, input logic [YEAR_W-1:0] y,
                             input logic [COUNT_W-1:0] cnt);
        int gap;
        int roll;
        t_date_result want;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60) begin
            gap = 0;
        end else if (roll < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_kind      <= kind;
        i_month_in  <= m;
        i_day_in    <= d;
        i_year_in   <= y;
        i_day_count <= cnt;
        cycle_allowance += 4 * (gap + cnt + 4);
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_date(kind, m, d, y, cnt, want);
        expected_dates.push_back(want);
        if (kind == KIND_LOAD) begin
            loads_sent++;
            if (want.status != ST_OK) begin
                loads_rejected++;
            end
        end else begin
            advances_sent++;
            days_requested += cnt;
            if (want.status == ST_OVERFLOW) begin
                overflow_beats++;
            end
        end
    endtask

    task automatic send_load(input int m, input int d, input int y);
        send_beat(KIND_LOAD, m, d, y, $urandom_range(0, FULL_COUNT));
    endtask

    task automatic send_advance(input int cnt);
        send_beat(KIND_ADVANCE, $urandom_range(0, 15), $urandom_range(0, 31),
                  $urandom_range(0, 4095), cnt);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch on beat %0d: %s is %0d, expected %0d",
                     beats_checked, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_dates.size() == 0) begin
                report_mismatch("unexpected result beat, status", o_status, 0);
            end else begin
                oldest_date = expected_dates.pop_front();
                if (o_out_month !== oldest_date.month) begin
                    report_mismatch("month", o_out_month, oldest_date.month);
                end
                if (o_out_day !== oldest_date.day) begin
                    report_mismatch("day", o_out_day, oldest_date.day);
                end
                if (o_out_year !== oldest_date.year) begin
                    report_mismatch("year", o_out_year, oldest_date.year);
                end
                if (o_status !== oldest_date.status) begin
                    report_mismatch("status", o_status, oldest_date.status);
                end
            end
            beats_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_allowance + SLACK_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_reset_date();
        send_advance(0);
        send_advance(1);
    endtask

    task automatic test_load_checks();
        send_load(0, 15, 2000);
        send_load(15, 40, 4095);
        send_load(13, 1, 2000);
        send_load(6, 10, 1899);
        send_load(6, 0, 2101);
        send_load(4, 31, 2050);
        send_load(1, 0, 1900);
        send_load(1, 31, 2100);
    endtask

    task automatic test_leap_rules();
        send_load(2, 29, 1900);
        send_load(2, 29, 2100);
        send_load(2, 29, 2023);
        send_load(2, 29, 2000);
        send_load(2, 29, 2024);
        send_advance(1);
    endtask

    task automatic test_rollover();
        send_load(12, 31, 2099);
        send_advance(1);
        send_load(2, 28, 2100);
        send_advance(1);
    endtask

    // Walking from the last loadable year to the year limit exercises every
    // century rule on the way and ends in the overflow status.
    task automatic test_year_limit();
        send_load(12, 31, 2100);
        repeat (12) send_advance(FULL_COUNT);
        send_advance(1);
        send_advance($urandom_range(0, FULL_COUNT));
        send_advance(0);
    endtask

    task automatic test_random_traffic();
        int n;
        int roll;
        int m;
        int d;
        int y;
        int len;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            m = $urandom_range(1, 12);
            y = ($urandom_range(0, 9) == 0) ? 1900 + 100 * $urandom_range(0, 2)
                                             : $urandom_range(1900, 2100);
            len = month_length(m, y);
            if (roll < 70) begin
                if (cal_year == YEAR_LIMIT && cal_month == MONTH_DEC && cal_day == 5'd31) begin
                    send_advance($urandom_range(0, FULL_COUNT));
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55) begin
                        send_advance($urandom_range(0, 1));
                    end else if (roll < 85) begin
                        send_advance($urandom_range(2, 40));
                    end else if (roll < 97) begin
                        send_advance($urandom_range(41, 800));
                    end else begin
                        send_advance($urandom_range(801, 6000));
                    end
                end
            end else if (roll < 90) begin
                d = ($urandom_range(0, 2) == 0) ? len : $urandom_range(1, len);
                send_load(m, d, y);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        send_load($urandom_range(0, 1) ? 0 : $urandom_range(13, 15),
                                  $urandom_range(0, 31), $urandom_range(0, 4095));
                    end
                    1: begin
                        send_load(m, $urandom_range(0, 31),
                                  $urandom_range(0, 1) ? $urandom_range(0, 1899)
                                                       : $urandom_range(2101, 4095));
                    end
                    2: begin
                        d = (len < 31 && $urandom_range(0, 1)) ? $urandom_range(len + 1, 31)
                                                               : 0;
                        send_load(m, d, y);
                    end
                    default: begin
                        send_load($urandom_range(0, 15), $urandom_range(0, 31),
                                  $urandom_range(0, 4095));
                    end
                endcase
            end
        end
    endtask

    initial begin
        cycle_allowance = 100;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_date();
        test_load_checks();
        test_leap_rules();
        test_rollover();
        test_year_limit();
        test_random_traffic();
        start <= 1'b0;
        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d loads (%0d rejected) and %0d advances over %0d days.",
                 loads_sent, loads_rejected, advances_sent, days_requested);
        $display("Checked %0d result beats, %0d of them at the year limit, in %0d cycles.",
                 beats_checked, overflow_beats, cycle_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== calendar_date_advance.f =====
rtl/cda_pkg.sv
rtl/cda_ctrl.sv
rtl/cda_datapath.sv
rtl/calendar_date_advance.sv
rtl/cda_checker.sv
tb/tb_calendar_date_advance.sv
